/* hw/rtl/ced_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ced_pkg;

  localparam int MAX_HEX_DIGITS = 16;
  localparam int DIGIT_W        = 5;
  localparam int ACCUM_W        = 64;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  // One decoded item: up to eight bytes of a hex value, then up to two plain bytes.
  typedef struct packed {
    logic [3:0]         hex_bytes;
    logic [ACCUM_W-1:0] value;
    logic [1:0]         tail_n;
    logic [7:0]         tail0;
    logic [7:0]         tail1;
  } ced_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/ced_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ced_front import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       queue_full,
  output logic       push,
  output ced_cmd_t   cmd
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX
  } mode_t;

  mode_t              mode, mode_next;
  logic [DIGIT_W-1:0] count, count_next, count_inc;
  logic [ACCUM_W-1:0] accum, accum_next, accum_inc;
  logic               is_digit, is_alpha, is_hex;
  logic [3:0]         hex_val;
  logic               accept;

  function automatic logic [3:0] flush_bytes(input logic [DIGIT_W-1:0] cnt);
    if (cnt <= DIGIT_W'(2)) begin
      return 4'd1;
    end else if (cnt <= DIGIT_W'(4)) begin
      return 4'd2;
    end else if (cnt <= DIGIT_W'(8)) begin
      return 4'd4;
    end
    return 4'd8;
  endfunction

  function automatic ced_cmd_t add_tail(input ced_cmd_t c, input logic [7:0] b);
    ced_cmd_t r;
    r = c;
    if (c.tail_n == 2'd0) begin
      r.tail0 = b;
    end else begin
      r.tail1 = b;
    end
    r.tail_n = c.tail_n + 2'd1;
    return r;
  endfunction

  function automatic ced_cmd_t add_flush(input ced_cmd_t c, input logic [DIGIT_W-1:0] cnt,
                                         input logic [ACCUM_W-1:0] acc);
    ced_cmd_t r;
    r = c;
    if (cnt == '0) begin
      r = add_tail(c, CH_X);
    end else begin
      r.hex_bytes = flush_bytes(cnt);
      r.value     = acc;
    end
    return r;
  endfunction

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign is_digit  = (in_byte >= "0") && (in_byte <= "9");
  assign is_alpha  = ((in_byte >= "a") && (in_byte <= "f")) ||
                     ((in_byte >= "A") && (in_byte <= "F"));
  assign is_hex    = is_digit || is_alpha;
  assign hex_val   = is_digit ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
  assign count_inc = count + DIGIT_W'(1);
  assign accum_inc = {accum[ACCUM_W-5:0], hex_val};

  always_comb begin
    cmd        = '0;
    mode_next  = mode;
    count_next = count;
    accum_next = accum;
    case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        case (in_byte)
          "0":       cmd = add_tail(cmd, 8'h00);
          "a":       cmd = add_tail(cmd, 8'h07);
          "b":       cmd = add_tail(cmd, 8'h08);
          "f":       cmd = add_tail(cmd, 8'h0C);
          "n":       cmd = add_tail(cmd, 8'h0A);
          "r":       cmd = add_tail(cmd, 8'h0D);
          "t":       cmd = add_tail(cmd, 8'h09);
          "v":       cmd = add_tail(cmd, 8'h0B);
          CH_BSLASH: cmd = add_tail(cmd, in_byte);
          "'":       cmd = add_tail(cmd, in_byte);
          "\"":      cmd = add_tail(cmd, in_byte);
          "?":       cmd = add_tail(cmd, in_byte);
          CH_X: begin
            mode_next  = MODE_HEX;
            count_next = '0;
            accum_next = '0;
          end
          default: begin
            cmd = add_tail(cmd, CH_BSLASH);
            cmd = add_tail(cmd, in_byte);
          end
        endcase
      end
      MODE_HEX: begin
        if (is_hex) begin
          count_next = count_inc;
          accum_next = accum_inc;
          if (count_inc >= DIGIT_W'(MAX_HEX_DIGITS)) begin
            cmd        = add_flush(cmd, count_inc, accum_inc);
            mode_next  = MODE_NORMAL;
            count_next = '0;
            accum_next = '0;
          end
        end else begin
          cmd        = add_flush(cmd, count, accum);
          count_next = '0;
          accum_next = '0;
          if (in_byte == CH_BSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            mode_next = MODE_NORMAL;
            cmd       = add_tail(cmd, in_byte);
          end
        end
      end
      default: begin
        if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          mode_next = MODE_NORMAL;
          cmd       = add_tail(cmd, in_byte);
        end
      end
    endcase
    if (in_eos) begin
      if (mode_next == MODE_ESCAPE) begin
        cmd = add_tail(cmd, CH_BSLASH);
      end else if (mode_next == MODE_HEX) begin
        cmd = add_flush(cmd, count_next, accum_next);
      end
      mode_next  = MODE_NORMAL;
      count_next = '0;
      accum_next = '0;
    end
  end

  assign push = accept && ((cmd.hex_bytes != 4'd0) || (cmd.tail_n != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      count <= '0;
      accum <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      count <= count_next;
      accum <= accum_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ced_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ced_queue import ced_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ced_cmd_t push_cmd,
  input  logic     pop,
  output ced_cmd_t head,
  output logic     not_empty,
  output logic     full
);

  ced_cmd_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr, rptr;
  logic [QUEUE_CW-1:0]   count;

  assign head      = entries[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == QUEUE_CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ced_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ced_back import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ced_cmd_t   head,
  input  logic       head_valid,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [3:0] idx;
  logic [3:0] total;
  logic       is_last;
  logic       load;
  logic [7:0] cur_byte;

  assign total   = head.hex_bytes + {2'b00, head.tail_n};
  assign is_last = (idx == (total - 4'd1));
  assign load    = head_valid && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_comb begin
    if (idx < head.hex_bytes) begin
      cur_byte = head.value[{idx[2:0], 3'b000} +: 8];
    end else if (idx == head.hex_bytes) begin
      cur_byte = head.tail0;
    end else begin
      cur_byte = head.tail1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= is_last ? 4'd0 : idx + 4'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_byte;
      m_tlast <= is_last;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/c_escape_sequence_decoder_core.sv */
// C string escape decoder.
// The slave channel takes one raw byte per word on s_tdata, with s_tlast
// marking the final byte of a stream; after that byte any pending escape is
// flushed and the decoder returns to plain text. The master channel gives one
// decoded byte per word on m_tdata, and m_tlast is set on the last byte that
// an input word produced. An input word that produces no byte (a backslash,
// the x of a hex escape, a hex digit) gives no output word.
// A front stage classifies each byte and writes one command per input word
// that yields bytes into a four-entry queue; a back stage reads the queue and
// sends its bytes one per cycle from an output register while the receiver
// takes them. From input accept, the first output word passes through the
// queue and then the output register.
// Throughput is one input word per cycle while each word yields at most one
// byte and the receiver does not stall; a word that yields several bytes (up
// to nine, for a hex value) holds the back stage while it sends them, and the
// queue lets input continue until it fills. When the receiver stalls,
// the output register holds its word, the queue fills and s_tready drops.
// Reset clears the parse state, the queue and the output register; s_tready is
// high in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module c_escape_sequence_decoder_core import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast
);

  ced_cmd_t push_cmd, head;
  logic     push, pop, not_empty, full;

  ced_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eos     (s_tlast),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  ced_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  ced_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire

/* hw/rtl/ced_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  localparam logic [7:0] BSLASH = 8'h5C;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("decoder not empty after reset");

  a_first_plain: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && s_tvalid && s_tready && (s_tdata != BSLASH)
      |=> ##1 (m_tvalid && (m_tdata == $past(s_tdata, 2)) && m_tlast))
    else $error("plain byte after reset not passed through");

endmodule

bind c_escape_sequence_decoder_core ced_checker u_ced_checker (.*);
`default_nettype wire

/* test/c_escape_sequence_decoder_core_tb.sv */
`timescale 1ns / 1ps
module c_escape_sequence_decoder_core_tb;
  import ced_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_WORD_BYTES = 9;
  localparam int TABLE_ROWS = 25;

  localparam logic [7:0] ESCAPE_LETTERS [12] = '{
    "0", "a", "b", "f", "n", "r", "t", "v", CH_BSLASH, 8'h27, 8'h22, "?"
  };

  typedef enum logic [1:0] {
    ST_TEXT,
    ST_ESCAPE,
    ST_HEX
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  parse_state_t state;
  int           digits;
  logic [63:0]  accum;
  logic [7:0]   word_bytes [$];
  out_word_t    expected_bytes [$];
  out_word_t    oldest;
  table_row_t   stim_table [TABLE_ROWS];

  int errors = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  c_escape_sequence_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual data=%02h last=%0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        oldest = expected_bytes.pop_front();
        if (m_tdata !== oldest.data) begin
          $display("%0t: data mismatch, expected %02h, actual %02h",
                   $time, oldest.data, m_tdata);
          errors++;
        end
        if (m_tlast !== oldest.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, oldest.last, m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic emit(input logic [7:0] b);
    if (word_bytes.size() < MAX_WORD_BYTES) word_bytes = {word_bytes, b};
  endtask

  task automatic flush_hex();
    int nb;
    int k;
    if (digits == 0) begin
      emit(CH_X);
    end else begin
      nb = (digits <= 2) ? 1 : (digits <= 4) ? 2 : (digits <= 8) ? 4 : 8;
      for (k = 0; k < nb; k++) emit(accum[8*k +: 8]);
      state = ST_TEXT;
      digits = 0;
      accum = '0;
    end
  endtask

  task automatic text_byte(input logic [7:0] c);
    if (c == CH_BSLASH) state = ST_ESCAPE;
    else emit(c);
  endtask

  task automatic escape_byte(input logic [7:0] c);
    state = ST_TEXT;
    case (c)
      "0": emit(8'h00);
      "a": emit(8'h07);
      "b": emit(8'h08);
      "f": emit(8'h0C);
      "n": emit(8'h0A);
      "r": emit(8'h0D);
      "t": emit(8'h09);
      "v": emit(8'h0B);
      CH_BSLASH, 8'h27, 8'h22, "?": emit(c);
      CH_X: begin
        state = ST_HEX;
        digits = 0;
        accum = '0;
      end
      default: begin
        emit(CH_BSLASH);
        emit(c);
      end
    endcase
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c[3:0]);
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return int'(c[3:0]) + 9;
    return -1;
  endfunction

  task automatic decode_word(input logic [7:0] c, input logic eos);
    int v;
    word_bytes.delete();
    case (state)
      ST_ESCAPE: escape_byte(c);
      ST_HEX: begin
        v = hex_digit(c);
        if (v >= 0) begin
          accum = {accum[59:0], 4'(v)};
          digits++;
          if (digits >= MAX_HEX_DIGITS) flush_hex();
        end else begin
          flush_hex();
          state = ST_TEXT;
          text_byte(c);
        end
      end
      default: begin
        state = ST_TEXT;
        text_byte(c);
      end
    endcase
    if (eos) begin
      if (state == ST_ESCAPE) emit(CH_BSLASH);
      else if (state == ST_HEX) flush_hex();
      state = ST_TEXT;
      digits = 0;
      accum = '0;
    end
  endtask

  task automatic queue_word_bytes();
    int k;
    out_word_t w;
    for (k = 0; k < word_bytes.size(); k++) begin
      w.data = word_bytes[k];
      w.last = (k == word_bytes.size() - 1);
      expected_bytes = {expected_bytes, w};
    end
  endtask

  task automatic send_word(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_checked(input logic [7:0] c, input logic eos);
    send_word(c, eos);
    decode_word(c, eos);
    queue_word_bytes();
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 10);
  endfunction

  function automatic table_row_t row(input logic [7:0] c, input logic eos, input logic typed,
                                     input logic [1:0] n, input logic [7:0] b0,
                                     input logic [7:0] b1);
    return '{data: c, eos: eos, typed: typed, n: n, b0: b0, b1: b1};
  endfunction

  task automatic random_sequence();
    int pick;
    int k;
    int count;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_checked(8'($urandom_range(255)), ($urandom_range(15) == 0));
    end else if (pick < 60) begin
      send_checked(CH_BSLASH, 1'b0);
      if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
      else c = ESCAPE_LETTERS[$urandom_range(11)];
      send_checked(c, ($urandom_range(15) == 0));
    end else if (pick < 92) begin
      send_checked(CH_BSLASH, 1'b0);
      count = ($urandom_range(3) == 0) ? MAX_HEX_DIGITS : $urandom_range(MAX_HEX_DIGITS - 1);
      send_checked(CH_X, (count == 0) && ($urandom_range(7) == 0));
      for (k = 0; k < count; k++)
        send_checked(random_hex_char(), (k == count - 1) && ($urandom_range(7) == 0));
      if (count < MAX_HEX_DIGITS && $urandom_range(9) < 7) begin
        c = ($urandom_range(3) == 0) ? CH_BSLASH : 8'($urandom_range(255));
        send_checked(c, ($urandom_range(9) == 0));
      end
    end else begin
      c = $urandom_range(1) ? CH_BSLASH : 8'($urandom_range(255));
      send_checked(c, 1'b1);
    end
  endtask

  initial begin
    int i;
    int phase;
    state = ST_TEXT;
    digits = 0;
    accum = '0;

    stim_table[0]  = row("A",       1'b0, 1'b1, 2'd1, "A",       8'h00);
    stim_table[1]  = row(8'h00,     1'b0, 1'b1, 2'd1, 8'h00,     8'h00);
    stim_table[2]  = row(8'hFF,     1'b1, 1'b1, 2'd1, 8'hFF,     8'h00);
    stim_table[3]  = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[4]  = row("n",       1'b0, 1'b1, 2'd1, 8'h0A,     8'h00);
    stim_table[5]  = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[6]  = row("0",       1'b0, 1'b1, 2'd1, 8'h00,     8'h00);
    stim_table[7]  = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[8]  = row(8'h00,     1'b0, 1'b1, 2'd2, CH_BSLASH, 8'h00);
    stim_table[9]  = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[10] = row(CH_X,      1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[11] = row("a",       1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[12] = row("B",       1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[13] = row(CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00);
    stim_table[14] = row(CH_X,      1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[15] = row("z",       1'b0, 1'b1, 2'd2, CH_X,      "z");
    stim_table[16] = row(CH_BSLASH, 1'b1, 1'b1, 2'd1, CH_BSLASH, 8'h00);
    stim_table[17] = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[18] = row(CH_X,      1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[19] = row("7",       1'b1, 1'b0, 2'd0, 8'h00,     8'h00);
    stim_table[20] = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[21] = row(CH_X,      1'b1, 1'b1, 2'd1, CH_X,      8'h00);
    stim_table[22] = row(CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00);
    stim_table[23] = row("?",       1'b0, 1'b1, 2'd1, "?",       8'h00);
    stim_table[24] = row(8'h80,     1'b0, 1'b1, 2'd1, 8'h80,     8'h00);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 56;
    for (i = 0; i < TABLE_ROWS; i++) begin
      send_word(stim_table[i].data, stim_table[i].eos);
      decode_word(stim_table[i].data, stim_table[i].eos);
      if (stim_table[i].typed) begin
        word_bytes.delete();
        if (stim_table[i].n > 0) word_bytes = {word_bytes, stim_table[i].b0};
        if (stim_table[i].n > 1) word_bytes = {word_bytes, stim_table[i].b1};
      end
      queue_word_bytes();
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (words_sent < TABLE_ROWS + 68 * (phase + 1)) random_sequence();
    end

    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
